// ===== hw/rtl/lpl_pkg.sv =====
// shared constants and widths for the lookahead peak limiter
package lpl_pkg;

  localparam int LPL_DELAY_DEPTH  = 512;
  localparam int LPL_SAMPLE_WIDTH = 16;

  localparam int GAIN_W     = 17;
  localparam int COEFF_W    = 16;
  localparam int CEIL_W     = 16;
  localparam int LEN_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'h10000;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd4;

  // register reset values
  localparam logic                RST_ENABLE  = 1'b1;
  localparam logic [CEIL_W-1:0]   RST_CEILING = 16'd29205;
  localparam logic [COEFF_W-1:0]  RST_RELEASE = 16'd65509;
  localparam logic [COEFF_W-1:0]  RST_ATTACK  = 16'd65264;
  localparam logic [LEN_W-1:0]    RST_LENGTH  = 9'd240;

endpackage

// ===== hw/rtl/lpl_cfg_if.sv =====
// configuration write channel
interface lpl_cfg_if import lpl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/lpl_in_if.sv =====
// input sample channel
interface lpl_in_if import lpl_pkg::*; #(
  parameter int SAMPLE_WIDTH = LPL_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;
  logic                           block_end;

  modport source (output valid, sample_in, block_end, input ready);
  modport sink   (input valid, sample_in, block_end, output ready);
endinterface

// ===== hw/rtl/lpl_out_if.sv =====
// result channel
interface lpl_out_if import lpl_pkg::*; #(
  parameter int SAMPLE_WIDTH = LPL_SAMPLE_WIDTH
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic [GAIN_W-1:0]              gain;
  logic                           block_end_out;

  modport source (output valid, sample_out, gain, block_end_out, input ready);
  modport sink   (input valid, sample_out, gain, block_end_out, output ready);
endinterface

// ===== hw/rtl/lpl_ram.sv =====
// generic simple dual-port ram with registered read
module lpl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/lpl_div.sv =====
// restoring divider, one quotient bit per cycle
module lpl_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    if (rem_sh >= {1'b0, den_r}) begin
      rem_nxt = rem_sub[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== hw/rtl/lookahead_peak_limiter_unit.sv =====
// lookahead peak limiter top level: sequencer, shared multiplier, ring and divider
//
//  channel  dir  handshake     beat
//  cfg_ch   in   valid/ready   index, data (always ready)
//  in_ch    in   valid/ready   sample_in, block_end
//  out_ch   out  valid/ready   sample_out, gain, block_end_out
//
// beat to beat in lookahead mode: a ring scan at one entry a cycle, ring length =
// min(lookahead_len+1, DELAY_DEPTH), then the divider unless the peak is under the ceiling;
// instant mode skips the scan (and the smoothing steps on an instant attack), bypass skips
// the scan, the divider and the smoothing.
// synchronous reset; ring contents are tracked by a fill count, no clearing pass.
// in_ch is ready only while the sequencer is idle; a held result stalls it at its last step.
module lookahead_peak_limiter_unit import lpl_pkg::*; #(
  parameter int DELAY_DEPTH  = LPL_DELAY_DEPTH,
  parameter int SAMPLE_WIDTH = LPL_SAMPLE_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  lpl_cfg_if.sink     cfg_ch,
  lpl_in_if.sink      in_ch,
  lpl_out_if.source   out_ch
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int AW    = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int CW    = $clog2(DELAY_DEPTH + 1);
  localparam int LW    = (CW > LEN_W + 1) ? CW : LEN_W + 1;
  localparam int MUL_W = (SW > GAIN_W) ? SW : GAIN_W;
  localparam int PW    = 2 * MUL_W;
  localparam int CMP_W = (SW > CEIL_W) ? SW : CEIL_W;
  localparam int NUM_W = ((SW - 1 > CEIL_W + 16) ? SW - 1 : CEIL_W + 16) + 1;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_RD     = 12'b0000_0000_0010,
    S_SCAN   = 12'b0000_0000_0100,
    S_TGT    = 12'b0000_0000_1000,
    S_DIV    = 12'b0000_0001_0000,
    S_CMP    = 12'b0000_0010_0000,
    S_SM1    = 12'b0000_0100_0000,
    S_SM2    = 12'b0000_1000_0000,
    S_SM3    = 12'b0001_0000_0000,
    S_APPLY1 = 12'b0010_0000_0000,
    S_APPLY2 = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  function automatic logic [SW-1:0] mag_of(input logic [SW-1:0] v);
    mag_of = v[SW-1] ? SW'(~v + SW'(1)) : v;
  endfunction

  // configuration
  logic               enable_r;
  logic [CEIL_W-1:0]  ceiling_r;
  logic [COEFF_W-1:0] release_r;
  logic [COEFF_W-1:0] attack_r;
  logic [LEN_W-1:0]   len_r;

  // sequencer and datapath
  state_t                state_r, state_nxt;
  logic signed [SW-1:0]  x_r;
  logic                  be_r;
  logic                  la_r;
  logic [SW-1:0]         delayed_r;
  logic [SW-1:0]         peak_r;
  logic [GAIN_W-1:0]     t_r;
  logic [GAIN_W-1:0]     g_r;
  logic [COEFF_W-1:0]    c_r;
  logic [PW-1:0]         prod_r;
  logic [PW-1:0]         acc_r;
  logic [SW-1:0]         y_r;
  logic [AW-1:0]         wp_r;
  logic [CW-1:0]         fill_r;
  logic [CW-1:0]         si_r;
  logic                  pv_r;
  logic [AW-1:0]         pidx_r;

  // output register
  logic                  out_valid_r;
  logic [SW-1:0]         out_sample_r;
  logic [GAIN_W-1:0]     out_gain_r;
  logic                  out_be_r;

  logic                  cfg_fire;
  logic                  in_fire;
  logic                  out_free;
  logic [LW-1:0]         len_p1;
  logic [CW-1:0]         n_w;
  logic [AW-1:0]         wp_eff;
  logic [AW-1:0]         wp_adv;
  logic                  rd_en;
  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [SW-1:0]         ram_rdata;
  logic [SW-1:0]         rd_mag;
  logic [SW-1:0]         src;
  logic [SW-1:0]         src_mag;
  logic                  over_ceiling;
  logic                  div_start;
  logic                  div_done;
  logic [NUM_W-1:0]      div_num;
  logic [NUM_W-1:0]      div_quot;
  logic [MUL_W-1:0]      mul_a;
  logic [MUL_W-1:0]      mul_b;
  logic [PW-1:0]         sm_sum;
  logic [PW-1:0]         ap_sum;
  logic [SW-1:0]         ap_mag;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && (state_r == S_IDLE);
  assign out_free     = !out_valid_r || out_ch.ready;

  // ring length, saturated at the memory depth
  assign len_p1 = LW'(len_r) + LW'(1);
  assign n_w    = (len_p1 > LW'(DELAY_DEPTH)) ? CW'(DELAY_DEPTH) : len_p1[CW-1:0];
  assign wp_eff = (CW'(wp_r) >= n_w) ? '0 : wp_r;
  assign wp_adv = (CW'(wp_r) + CW'(1) >= n_w) ? '0 : AW'(CW'(wp_r) + CW'(1));

  assign rd_en     = (state_r == S_SCAN) && (si_r < n_w);
  assign ram_we    = (state_r == S_RD);
  assign ram_raddr = (state_r == S_IDLE) ? wp_eff : si_r[AW-1:0];
  assign rd_mag    = mag_of(ram_rdata);

  assign src     = la_r ? delayed_r : x_r;
  assign src_mag = mag_of(src);

  assign over_ceiling = CMP_W'(peak_r) > CMP_W'(ceiling_r);
  assign div_start    = (state_r == S_TGT) && over_ceiling;
  assign div_num      = {ceiling_r, 16'h0} + NUM_W'(peak_r >> 1);

  assign sm_sum = acc_r + prod_r + PW'(32768);
  assign ap_sum = prod_r + PW'(32768);
  assign ap_mag = ap_sum[16 +: SW];

  lpl_ram #(
    .WIDTH (SW),
    .DEPTH (DELAY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (x_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpl_div #(
    .NUM_W (NUM_W),
    .DEN_W (SW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (peak_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      S_SM1: begin
        mul_a = MUL_W'(c_r);
        mul_b = MUL_W'(g_r);
      end
      S_SM2: begin
        mul_a = MUL_W'(UNITY_GAIN - GAIN_W'(c_r));
        mul_b = MUL_W'(t_r);
      end
      default: begin
        mul_a = MUL_W'(src_mag);
        mul_b = MUL_W'(g_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!enable_r) begin
            state_nxt = S_DONE;
          end else if (len_r == '0) begin
            state_nxt = S_TGT;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD:     state_nxt = S_SCAN;
      S_SCAN: begin
        if (!rd_en && !pv_r) begin
          state_nxt = S_TGT;
        end
      end
      S_TGT:    state_nxt = over_ceiling ? S_DIV : S_CMP;
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (!la_r && (t_r < g_r)) begin
          state_nxt = S_APPLY1;
        end else begin
          state_nxt = S_SM1;
        end
      end
      S_SM1:    state_nxt = S_SM2;
      S_SM2:    state_nxt = S_SM3;
      S_SM3:    state_nxt = S_APPLY1;
      S_APPLY1: state_nxt = S_APPLY2;
      S_APPLY2: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= RST_ENABLE;
      ceiling_r   <= RST_CEILING;
      release_r   <= RST_RELEASE;
      attack_r    <= RST_ATTACK;
      len_r       <= RST_LENGTH;
      wp_r        <= '0;
      fill_r      <= '0;
      g_r         <= UNITY_GAIN;
      si_r        <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_fire) begin
        case (cfg_ch.index)
          REG_ENABLE:  enable_r  <= cfg_ch.data[0];
          REG_CEILING: ceiling_r <= cfg_ch.data[CEIL_W-1:0];
          REG_RELEASE: release_r <= cfg_ch.data[COEFF_W-1:0];
          REG_ATTACK:  attack_r  <= cfg_ch.data[COEFF_W-1:0];
          REG_LENGTH: begin
            len_r  <= cfg_ch.data[LEN_W-1:0];
            // empty ring: nothing below the fill count
            wp_r   <= '0;
            fill_r <= '0;
          end
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire && enable_r && (len_r != '0)) begin
            wp_r <= wp_eff;
          end
        end
        S_RD: begin
          wp_r <= wp_adv;
          if (CW'(wp_r) >= fill_r) begin
            fill_r <= fill_r + CW'(1);
          end
          si_r <= '0;
          pv_r <= 1'b0;
        end
        S_SCAN: begin
          pv_r <= rd_en;
          if (rd_en) begin
            si_r <= si_r + CW'(1);
          end
        end
        S_CMP: begin
          if (!la_r && (t_r < g_r)) begin
            g_r <= t_r;
          end
        end
        S_SM3: begin
          g_r <= sm_sum[16 +: GAIN_W];
        end
        default: ;
      endcase

      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          x_r     <= in_ch.sample_in;
          be_r    <= in_ch.block_end;
          la_r    <= (len_r != '0);
          y_r     <= in_ch.sample_in;
          peak_r  <= mag_of(in_ch.sample_in);
        end
      end
      S_RD: begin
        delayed_r <= (CW'(wp_r) < fill_r) ? ram_rdata : '0;
        peak_r    <= '0;
      end
      S_SCAN: begin
        // read data returns in the cycle after its address is issued
        if (pv_r && (CW'(pidx_r) < fill_r) && (rd_mag > peak_r)) begin
          peak_r <= rd_mag;
        end
        pidx_r <= si_r[AW-1:0];
      end
      S_TGT: begin
        t_r <= UNITY_GAIN;
      end
      S_DIV: begin
        if (div_done) begin
          t_r <= div_quot[GAIN_W-1:0];
        end
      end
      S_CMP: begin
        c_r <= (la_r && (t_r < g_r)) ? attack_r : release_r;
      end
      S_SM2: begin
        acc_r <= prod_r;
      end
      S_APPLY2: begin
        y_r <= src[SW-1] ? SW'(~ap_mag + SW'(1)) : ap_mag;
      end
      default: ;
    endcase

    if (state_r == S_DONE && out_free) begin
      out_sample_r <= y_r;
      out_gain_r   <= g_r;
      out_be_r     <= be_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_out    = out_sample_r;
  assign out_ch.gain          = out_gain_r;
  assign out_ch.block_end_out = out_be_r;

endmodule

// ===== bench/lpl_limit_checker.sv =====
`timescale 1ns / 100ps
// watches the limiter channels, predicts each limited beat and compares it
module lpl_limit_checker import lpl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lpl_cfg_if   cfg_mon,
  lpl_in_if    in_mon,
  lpl_out_if   out_mon,
  output int   mismatches,
  output int   outstanding,
  output int   compared
);

  typedef logic signed [LPL_SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [GAIN_W-1:0] gain_t;
  typedef logic [63:0] u64_t;

  typedef struct packed {
    sample_t sample;
    gain_t   gain;
    logic    block_end;
  } limited_beat_t;

  logic               enable_r;
  logic [CEIL_W-1:0]  ceiling_r;
  logic [COEFF_W-1:0] release_r;
  logic [COEFF_W-1:0] attack_r;
  logic [LEN_W-1:0]   length_r;
  sample_t            ring [LPL_DELAY_DEPTH];
  int unsigned        wr_pos;
  gain_t              gain_r;

  limited_beat_t limited_beats_q[$];

  function automatic void clear_ring();
    for (int i = 0; i < LPL_DELAY_DEPTH; i++) ring[i] = '0;
    wr_pos = 0;
  endfunction

  function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ENABLE:  enable_r  = val[0];
      REG_CEILING: ceiling_r = val[CEIL_W-1:0];
      REG_RELEASE: release_r = val[COEFF_W-1:0];
      REG_ATTACK:  attack_r  = val[COEFF_W-1:0];
      REG_LENGTH: begin
        length_r = val[LEN_W-1:0];
        clear_ring();
      end
      default: ;
    endcase
  endfunction

  function automatic u64_t magnitude(sample_t x);
    longint sx;
    sx = x;
    return (sx < 0) ? u64_t'(-sx) : u64_t'(sx);
  endfunction

  // ceiling/peak in Q1.16, rounded; unity while the peak sits under the ceiling
  function automatic gain_t target_gain(u64_t peak);
    u64_t num;
    if (peak <= {48'd0, ceiling_r}) return UNITY_GAIN;
    num = ({48'd0, ceiling_r} << 16) + peak / 2;
    return gain_t'(num / peak);
  endfunction

  function automatic gain_t one_pole(logic [COEFF_W-1:0] c, gain_t g, gain_t t);
    u64_t acc;
    acc = {48'd0, c} * {47'd0, g} + (64'd65536 - {48'd0, c}) * {47'd0, t} + 64'd32768;
    return acc[16 +: GAIN_W];
  endfunction

  // rounds the magnitude half away from zero, sign put back afterwards
  function automatic sample_t scale_sample(sample_t x, gain_t g);
    u64_t m;
    m = (magnitude(x) * {47'd0, g} + 64'd32768) >> 16;
    return (x < 0) ? sample_t'(-longint'(m)) : sample_t'(m);
  endfunction

  function automatic limited_beat_t limit_sample(sample_t x, logic be);
    limited_beat_t r;
    sample_t       delayed;
    int unsigned   n;
    u64_t          peak;
    u64_t          a;
    gain_t         t;
    int            i;
    r.block_end = be;
    if (!enable_r) begin
      r.sample = x;
    end else if (length_r == 0) begin
      t = target_gain(magnitude(x));
      gain_r = (t < gain_r) ? t : one_pole(release_r, gain_r, t);
      r.sample = scale_sample(x, gain_r);
    end else begin
      n = length_r + 1;
      if (n > LPL_DELAY_DEPTH) n = LPL_DELAY_DEPTH;
      if (wr_pos >= n) wr_pos = 0;
      delayed = ring[wr_pos];
      ring[wr_pos] = x;
      peak = 0;
      for (i = 0; i < n; i++) begin
        a = magnitude(ring[i]);
        if (a > peak) peak = a;
      end
      t = target_gain(peak);
      gain_r = one_pole((t < gain_r) ? attack_r : release_r, gain_r, t);
      r.sample = scale_sample(delayed, gain_r);
      wr_pos = (wr_pos + 1 >= n) ? 0 : wr_pos + 1;
    end
    r.gain = gain_r;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    limited_beat_t got;
    limited_beat_t want;
    if (!rst_n) begin
      enable_r  = RST_ENABLE;
      ceiling_r = RST_CEILING;
      release_r = RST_RELEASE;
      attack_r  = RST_ATTACK;
      length_r  = RST_LENGTH;
      clear_ring();
      gain_r = UNITY_GAIN;
      limited_beats_q.delete();
      outstanding <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) write_register(cfg_mon.index, cfg_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        got.sample    = out_mon.sample_out;
        got.gain      = out_mon.gain;
        got.block_end = out_mon.block_end_out;
        if (limited_beats_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: beat with nothing expected: sample %0d gain %0d end %0b",
                     $realtime, got.sample, got.gain, got.block_end);
          mismatches++;
        end else begin
          want = limited_beats_q.pop_front();
          compared++;
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: beat %0d exp sample %0d gain %0d end %0b, got %0d %0d %0b",
                       $realtime, compared, want.sample, want.gain, want.block_end,
                       got.sample, got.gain, got.block_end);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        limited_beats_q.push_back(limit_sample(in_mon.sample_in, in_mon.block_end));
      outstanding <= limited_beats_q.size();
    end
  end

endmodule

// ===== bench/lookahead_peak_limiter_unit_tb.sv =====
`timescale 1ns / 100ps
// stimulus, result back-pressure and verdict for the lookahead peak limiter
module lookahead_peak_limiter_unit_tb;
  import lpl_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_GAP       = 14;
  localparam int SETTLE_CYCLES = 600;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;  // not decoded by the block

  typedef logic signed [LPL_SAMPLE_WIDTH-1:0] sample_t;

  logic clk    = 1'b0;
  logic rst_n  = 1'b0;
  logic steady = 1'b0;  // no idling on either side while set

  int fails;
  int in_flight;
  int checked;
  int samples_sent;
  int settings_used;
  int cycles;
  int cur_len = int'(RST_LENGTH);
  logic [CEIL_W-1:0] cur_ceiling = RST_CEILING;

  lpl_cfg_if cfg_ch ();
  lpl_in_if  in_ch ();
  lpl_out_if out_ch ();

  lookahead_peak_limiter_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lpl_limit_checker gain_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_mon     (cfg_ch),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (fails),
    .outstanding (in_flight),
    .compared    (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int pick_gap();
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // mix of full-scale noise, quiet passages and peaks around the ceiling
  function automatic sample_t audio_sample();
    int unsigned pick;
    int          lo;
    int          mag;
    pick = $urandom_range(0, 9);
    if (pick < 4) return sample_t'($urandom);
    if (pick < 7) begin
      mag = $urandom_range(0, 8000);
    end else begin
      lo = (cur_ceiling > 32767) ? 32767 : cur_ceiling;
      lo = (lo > 2000) ? lo - 2000 : 0;
      mag = $urandom_range(lo, 32767);
    end
    return $urandom_range(0, 1) ? sample_t'(-mag) : sample_t'(mag);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    if (idx == REG_LENGTH) cur_len = int'(val[LEN_W-1:0]);
    if (idx == REG_CEILING) cur_ceiling = val;
  endtask

  task automatic send_sample(input sample_t s, input logic be, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.sample_in = s;
    in_ch.block_end = be;
    do @(posedge clk); while (!in_ch.ready);
    samples_sent++;
  endtask

  // hold the sender until every expected beat has come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    do @(posedge clk); while (in_flight != 0);
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin : stimulus
    int                 n_items;
    logic               en_v;
    logic [CEIL_W-1:0]  ceil_v;
    logic [COEFF_W-1:0] rel_v;
    logic [COEFF_W-1:0] att_v;
    logic [LEN_W-1:0]   len_v;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    in_ch.block_end = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_ENABLE;
    cfg_ch.data     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: lookahead of 240
    send_sample(32767, 1'b0, pick_gap());
    send_sample(-32768, 1'b1, pick_gap());
    send_sample(0, 1'b0, pick_gap());
    send_sample(-1, 1'b1, pick_gap());
    send_sample(1, 1'b0, pick_gap());
    send_sample(20000, 1'b1, pick_gap());
    drain();
    // instant mode: attack at once, then release
    write_reg(REG_LENGTH, 16'd0);
    send_sample(32767, 1'b0, pick_gap());
    send_sample(-32768, 1'b1, pick_gap());
    send_sample(29205, 1'b0, pick_gap());
    send_sample(29206, 1'b1, pick_gap());
    send_sample(0, 1'b0, pick_gap());
    send_sample(1, 1'b1, pick_gap());
    send_sample(-1, 1'b0, pick_gap());
    drain();
    // zero ceiling pulls any nonzero peak to zero gain
    write_reg(REG_CEILING, 16'd0);
    send_sample(100, 1'b1, pick_gap());
    send_sample(0, 1'b0, pick_gap());
    drain();
    write_reg(REG_CEILING, 16'd32768);
    write_reg(REG_RELEASE, 16'd0);
    write_reg(REG_ATTACK, 16'hFFFF);
    send_sample(-32768, 1'b1, pick_gap());
    send_sample(32767, 1'b0, pick_gap());
    drain();
    write_reg(REG_CEILING, 16'd16423);
    write_reg(REG_LENGTH, 16'd1);
    send_sample(32767, 1'b1, pick_gap());
    send_sample(-32768, 1'b0, pick_gap());
    send_sample(5, 1'b1, pick_gap());
    drain();
    // bypass leaves ring and gain alone
    write_reg(REG_ENABLE, 16'd0);
    send_sample(-32768, 1'b0, pick_gap());
    send_sample(32767, 1'b1, pick_gap());
    send_sample(12345, 1'b0, pick_gap());
    drain();
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_ENABLE, 16'd1);
    send_sample(7, 1'b1, pick_gap());
    settings_used = 6;

    for (int p = 0; p < 12; p++) begin
      drain();
      steady = ($urandom_range(0, 3) == 0);
      en_v   = 1'b1;
      ceil_v = CEIL_W'($urandom_range(16423, 32768));
      rel_v  = $urandom_range(0, 1) ? COEFF_W'($urandom_range(60000, 65535))
                                    : COEFF_W'($urandom_range(0, 65535));
      att_v  = $urandom_range(0, 1) ? COEFF_W'($urandom_range(60000, 65535))
                                    : COEFF_W'($urandom_range(0, 65535));
      len_v  = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(13, 60))
                                           : LEN_W'($urandom_range(0, 12));
      case (p)
        0: len_v = 9'd511;
        1: len_v = 9'd0;
        2: en_v = 1'b0;
        3: ceil_v = 16'd0;
        4: begin
          rel_v = 16'd0;
          att_v = 16'd0;
        end
        5: begin
          rel_v = 16'hFFFF;
          att_v = 16'hFFFF;
        end
        6: ceil_v = 16'hFFFF;
        default: ;
      endcase
      write_reg(REG_ENABLE, {15'd0, en_v});
      write_reg(REG_CEILING, ceil_v);
      write_reg(REG_RELEASE, rel_v);
      write_reg(REG_ATTACK, att_v);
      // sometimes keep the ring contents across a change of the other registers
      if (p < 8 || $urandom_range(0, 1)) write_reg(REG_LENGTH, {7'd0, len_v});
      settings_used++;
      n_items = (cur_len > 64) ? 25 : 65;
      for (int i = 0; i < n_items; i++) begin
        if (p % 4 == 2 && i == n_items / 2) drain();
        send_sample(audio_sample(), $urandom_range(0, 1), pick_gap());
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d samples sent under %0d register settings, %0d limited beats compared",
             samples_sent, settings_used, checked);
    $display("bypass, instant mode, lookahead up to 511, edge ceilings, extreme coefficients");
    if (fails == 0 && in_flight == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
